// ===== hdl/des_cbc_retail_mac_macros.svh =====
// assertion macros shared by the des cbc retail mac project
`ifndef DES_CBC_RETAIL_MAC_MACROS_SVH
`define DES_CBC_RETAIL_MAC_MACROS_SVH

// condition a implies condition b in the same cycle
`define DCRM_ASSERT_SAME(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("dcrm check failed");

// condition a implies condition b in the next cycle
`define DCRM_ASSERT_NEXT(lbl, clk, rst, a, b) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("dcrm check failed");

`endif

// ===== hdl/dcrm_pkg.sv =====
// ----------------------------------------------------------------------------
// dcrm_pkg
// Types, register codes, DES tables and permutation functions.
// ----------------------------------------------------------------------------
package dcrm_pkg;

   localparam int MAX_MESSAGE_BYTES_DEF = 1024;

   localparam logic [2:0] REG_KEY_ONE   = 3'd0;
   localparam logic [2:0] REG_KEY_TWO   = 3'd1;
   localparam logic [2:0] REG_KEY_THREE = 3'd2;
   localparam logic [2:0] REG_KEY_LEN   = 3'd3;
   localparam logic [2:0] REG_MAC_MODE  = 3'd4;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_PARM = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   localparam logic [3:0] ALG_ONE   = 4'h0;
   localparam logic [3:0] ALG_THREE = 4'h2;
   localparam logic [3:0] PAD_ZERO  = 4'h0;
   localparam logic [3:0] PAD_ISO   = 4'h1;

   localparam logic [4:0] KEYLEN_SINGLE = 5'd8;
   localparam logic [4:0] KEYLEN_DOUBLE = 5'd16;
   localparam logic [4:0] KEYLEN_TRIPLE = 5'd24;

   typedef struct packed {
      logic [63:0] key_one;
      logic [63:0] key_two;
      logic [63:0] key_three;
      logic [4:0]  key_length_bytes;
      logic [7:0]  mac_mode;
   } cfg_type;

   typedef struct packed {
      logic [63:0] data;
      logic [3:0]  nv;
      logic        last;
      logic        bad;
   } item_type;

   localparam byte unsigned TAB_IP [64] = '{
      58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,62,54,46,38,30,22,14,6,
      64,56,48,40,32,24,16,8,57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};
   localparam byte unsigned TAB_FP [64] = '{
      40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,38,6,46,14,54,22,62,30,
      37,5,45,13,53,21,61,29,36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};
   localparam byte unsigned TAB_E [48] = '{
      32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
      16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};
   localparam byte unsigned TAB_P [32] = '{
      16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};
   localparam byte unsigned TAB_PC1 [56] = '{
      57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,
      60,52,44,36,63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,
      29,21,13,5,28,20,12,4};
   localparam byte unsigned TAB_PC2 [48] = '{
      14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
      41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
   localparam logic [1:0] TAB_ROT [16] = '{
      2'd1,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1,2'd2,2'd2,2'd2,2'd2,2'd2,2'd2,2'd1};
   localparam logic [3:0] TAB_S [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   // table entries count bit positions from the msb, starting at one
   function automatic logic [63:0] perm_ip(input logic [63:0] x);
      logic [63:0] o;
      for (int i = 0; i < 64; i++) o[63-i] = x[64-TAB_IP[i]];
      return o;
   endfunction

   function automatic logic [63:0] perm_fp(input logic [63:0] x);
      logic [63:0] o;
      for (int i = 0; i < 64; i++) o[63-i] = x[64-TAB_FP[i]];
      return o;
   endfunction

   function automatic logic [55:0] perm_pc1(input logic [63:0] x);
      logic [55:0] o;
      for (int i = 0; i < 56; i++) o[55-i] = x[64-TAB_PC1[i]];
      return o;
   endfunction

   function automatic logic [47:0] perm_pc2(input logic [55:0] x);
      logic [47:0] o;
      for (int i = 0; i < 48; i++) o[47-i] = x[56-TAB_PC2[i]];
      return o;
   endfunction

   function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] e;
      logic [5:0]  b;
      logic [31:0] s;
      logic [31:0] o;
      for (int i = 0; i < 48; i++) e[47-i] = r[32-TAB_E[i]];
      e = e ^ k;
      for (int i = 0; i < 8; i++) begin
         b = e[47-6*i -: 6];
         s[31-4*i -: 4] = TAB_S[i][{b[5], b[0], b[4:1]}];
      end
      for (int i = 0; i < 32; i++) o[31-i] = s[32-TAB_P[i]];
      return o;
   endfunction

   function automatic logic [55:0] rot_left(input logic [55:0] cd, input logic [1:0] n);
      logic [27:0] c;
      logic [27:0] d;
      c = cd[55:28];
      d = cd[27:0];
      if (n == 2'd2) return {c[25:0], c[27:26], d[25:0], d[27:26]};
      return {c[26:0], c[27], d[26:0], d[27]};
   endfunction

   function automatic logic [55:0] rot_right(input logic [55:0] cd, input logic [1:0] n);
      logic [27:0] c;
      logic [27:0] d;
      c = cd[55:28];
      d = cd[27:0];
      if (n == 2'd2) return {c[1:0], c[27:2], d[1:0], d[27:2]};
      return {c[0], c[27:1], d[0], d[27:1]};
   endfunction

endpackage

// ===== hdl/des_cbc_retail_mac.sv =====
// Each block takes one DES pass (single DES) or three DES passes (used for ede
// keys and for the final retail MAC steps), run by the one-round DES unit.
// A block can be accepted every cycle into a two-entry queue while it has room;
// the engine takes the next one when it is free, and registers the MAC from the last round.
// Reset (synchronous, active high) clears chaining, length count, queue and output,
// and sets the key length to 8 bytes with all keys and the mode zero.
// ----------------------------------------------------------------------------
// des_cbc_retail_mac
// ISO 9797-1 MAC algorithm 1 and 3 over DES, CBC chained, block at a time.
// ----------------------------------------------------------------------------
module des_cbc_retail_mac
   import dcrm_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // data_block[63:0], valid_bytes[67:64], zero fill
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // mac_value[63:0]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_KEY_ONE:   cfg_in.key_one          = csr_data;
            REG_KEY_TWO:   cfg_in.key_two          = csr_data;
            REG_KEY_THREE: cfg_in.key_three        = csr_data;
            REG_KEY_LEN:   cfg_in.key_length_bytes = csr_data[4:0];
            REG_MAC_MODE:  cfg_in.mac_mode         = csr_data[7:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.key_one          <= 64'd0;
         cfg_ff.key_two          <= 64'd0;
         cfg_ff.key_three        <= 64'd0;
         cfg_ff.key_length_bytes <= KEYLEN_SINGLE;
         cfg_ff.mac_mode         <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dcrm_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .data_block  (req_tdata[63:0]),
      .valid_bytes (req_tdata[67:64]),
      .last_block  (req_tlast),
      .cfg         (cfg_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   dcrm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   dcrm_engine #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .mac_value  (rsp_tdata),
      .status     (rsp_tuser)
   );

endmodule

// ===== hdl/dcrm_front.sv =====
// ----------------------------------------------------------------------------
// dcrm_front
// Accepts message blocks, clamps the byte count, pads and checks parameters.
// ----------------------------------------------------------------------------
module dcrm_front
   import dcrm_pkg::*;
(
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] data_block,
   input  logic [3:0]  valid_bytes,
   input  logic        last_block,
   input  cfg_type     cfg,
   output logic        push_valid,
   input  logic        push_ready,
   output item_type    push_item
);

   logic [3:0] nv;
   logic [3:0] pad_nib;
   logic [3:0] alg_nib;
   logic       bad_mode;
   logic       bad_len;
   logic [63:0] padded;

   always_comb begin
      nv = 4'd8;
      if (last_block && valid_bytes < 4'd8) nv = valid_bytes;
   end

   assign pad_nib  = cfg.mac_mode[7:4];
   assign alg_nib  = cfg.mac_mode[3:0];
   assign bad_mode = (pad_nib != PAD_ZERO && pad_nib != PAD_ISO) ||
                     (alg_nib != ALG_ONE && alg_nib != ALG_THREE);
   assign bad_len  = cfg.key_length_bytes != KEYLEN_SINGLE &&
                     cfg.key_length_bytes != KEYLEN_DOUBLE &&
                     cfg.key_length_bytes != KEYLEN_TRIPLE;

   // byte 0 is the top byte; bytes past the count take the padding
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         if (i < int'(nv))
            padded[63-8*i -: 8] = data_block[63-8*i -: 8];
         else if (i == int'(nv) && pad_nib == PAD_ISO)
            padded[63-8*i -: 8] = 8'h80;
         else
            padded[63-8*i -: 8] = 8'h00;
      end
   end

   assign req_tready     = push_ready;
   assign push_valid     = req_tvalid;
   assign push_item.data = padded;
   assign push_item.nv   = nv;
   assign push_item.last = last_block;
   assign push_item.bad  = bad_mode || bad_len || (last_block && nv == 4'd0);

endmodule

// ===== hdl/dcrm_queue.sv =====
// ----------------------------------------------------------------------------
// dcrm_queue
// Two-entry request queue between the front end and the cipher engine.
// ----------------------------------------------------------------------------
module dcrm_queue
   import dcrm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type   entry_ff [2];
   item_type   entry_in [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_item   = entry_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      entry_in = entry_ff;
      if (do_push) entry_in[wptr_ff] = push_item;
      wptr_in  = wptr_ff ^ do_push;
      rptr_in  = rptr_ff ^ do_pop;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/dcrm_engine.sv =====
// ----------------------------------------------------------------------------
// dcrm_engine
// Iterative DES round unit with CBC chaining, length tracking and result reg.
// ----------------------------------------------------------------------------
`include "des_cbc_retail_mac_macros.svh"

module dcrm_engine
   import dcrm_pkg::*;
#(
   parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  item_type    pop_item,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] mac_value,
   output logic [1:0]  status
);

   localparam int CNT_W = $clog2(MAX_MESSAGE_BYTES + 2);
   localparam logic [CNT_W:0] MAX_BYTES = (CNT_W+1)'(MAX_MESSAGE_BYTES);

   logic             busy_ff, busy_in;
   logic [3:0]       round_ff, round_in;
   logic [1:0]       pass_ff, pass_in;
   logic             ede_ff, ede_in;
   logic             last_ff, last_in;
   logic             bad_ff, bad_in;
   logic [31:0]      l_ff, l_in, r_ff, r_in;
   logic [55:0]      cd_ff, cd_in;
   logic [63:0]      chain_ff, chain_in;
   logic [CNT_W-1:0] bytes_ff, bytes_in;
   logic             long_ff, long_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      mac_ff, mac_in;
   logic [1:0]       status_ff, status_in;

   logic             dec;
   logic [55:0]      cd_use;
   logic [31:0]      new_r;
   logic [63:0]      res;
   logic [63:0]      k3_sel;
   logic [63:0]      next_key;
   logic [63:0]      ip_blk;
   logic [CNT_W:0]   sum;
   logic             multi_key;
   logic             stall;

   assign dec       = pass_ff == 2'd1;
   assign cd_use    = dec ? cd_ff : rot_left(cd_ff, TAB_ROT[round_ff]);
   assign new_r     = l_ff ^ feistel(r_ff, perm_pc2(cd_use));
   assign res       = perm_fp({new_r, r_ff});
   assign k3_sel    = (cfg.key_length_bytes == KEYLEN_TRIPLE) ? cfg.key_three : cfg.key_one;
   assign next_key  = (pass_ff == 2'd0) ? cfg.key_two : k3_sel;
   assign ip_blk    = perm_ip(chain_ff ^ pop_item.data);
   assign sum       = {1'b0, bytes_ff} + (CNT_W+1)'(pop_item.nv);
   assign multi_key = cfg.key_length_bytes == KEYLEN_DOUBLE ||
                      cfg.key_length_bytes == KEYLEN_TRIPLE;
   assign stall     = last_ff && rsp_valid_ff && !rsp_tready;
   assign pop_ready = !busy_ff;

   always_comb begin
      busy_in      = busy_ff;
      round_in     = round_ff;
      pass_in      = pass_ff;
      ede_in       = ede_ff;
      last_in      = last_ff;
      bad_in       = bad_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      cd_in        = cd_ff;
      chain_in     = chain_ff;
      bytes_in     = bytes_ff;
      long_in      = long_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      mac_in       = mac_ff;
      status_in    = status_ff;

      if (!busy_ff) begin
         if (pop_valid) begin
            busy_in  = 1'b1;
            round_in = 4'd0;
            pass_in  = 2'd0;
            // three passes for ede chaining or the final retail steps
            ede_in   = multi_key &&
                       (cfg.mac_mode[3:0] != ALG_THREE || pop_item.last);
            last_in  = pop_item.last;
            bad_in   = pop_item.bad;
            {l_in, r_in} = ip_blk;
            cd_in    = perm_pc1(cfg.key_one);
            if (sum > MAX_BYTES) begin
               long_in  = 1'b1;
               bytes_in = CNT_W'(MAX_MESSAGE_BYTES + 1);
            end else begin
               bytes_in = sum[CNT_W-1:0];
            end
         end
      end else if (round_ff != 4'd15) begin
         round_in = round_ff + 4'd1;
         l_in     = r_ff;
         r_in     = new_r;
         cd_in    = dec ? rot_right(cd_ff, TAB_ROT[4'd15 - round_ff]) : cd_use;
      end else if (ede_ff && pass_ff != 2'd2) begin
         pass_in  = pass_ff + 2'd1;
         round_in = 4'd0;
         {l_in, r_in} = perm_ip(res);
         cd_in    = perm_pc1(next_key);
      end else if (!stall) begin
         busy_in = 1'b0;
         if (last_ff) begin
            rsp_valid_in = 1'b1;
            chain_in     = 64'd0;
            bytes_in     = '0;
            long_in      = 1'b0;
            if (bad_ff) begin
               mac_in    = 64'd0;
               status_in = STATUS_BAD_PARM;
            end else if (long_ff) begin
               mac_in    = 64'd0;
               status_in = STATUS_TOO_LONG;
            end else begin
               mac_in    = res;
               status_in = STATUS_OK;
            end
         end else begin
            chain_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      round_ff  <= round_in;
      pass_ff   <= pass_in;
      ede_ff    <= ede_in;
      last_ff   <= last_in;
      bad_ff    <= bad_in;
      l_ff      <= l_in;
      r_ff      <= r_in;
      cd_ff     <= cd_in;
      mac_ff    <= mac_in;
      status_ff <= status_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         chain_ff     <= 64'd0;
         bytes_ff     <= '0;
         long_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         chain_ff     <= chain_in;
         bytes_ff     <= bytes_in;
         long_ff      <= long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign mac_value  = mac_ff;
   assign status     = status_ff;

   // the round counter rests at the last round once a block is done
   `DCRM_ASSERT_SAME(a_idle_round, clock, reset, !busy_ff, round_ff == 4'd15 || !$past(busy_ff))
   `DCRM_ASSERT_SAME(a_pass_ede, clock, reset, busy_ff && pass_ff != 2'd0, ede_ff)
   `DCRM_ASSERT_SAME(a_err_zero, clock, reset, rsp_valid_ff && status_ff != STATUS_OK,
                     mac_ff == 64'd0)
   `DCRM_ASSERT_NEXT(a_len_reset, clock, reset, busy_ff && !busy_in && last_ff,
                     bytes_ff == '0 && !long_ff && chain_ff == 64'd0)

endmodule

// ===== verif/tb_des_cbc_retail_mac.sv =====
// ----------------------------------------------------------------------------
// tb_des_cbc_retail_mac
// Checks the DES CBC MAC block (ISO 9797-1 algorithms 1 and 3) against a
// behavioral DES chain. A directed table covers the key lengths, both
// algorithms, both paddings and the parameter errors. Random messages follow,
// two of them near the length limit, under random flow control.
// ----------------------------------------------------------------------------
module tb_des_cbc_retail_mac;
   import dcrm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET  = 450;
   localparam int DRAIN_CYCLES = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int MAX_MSG      = 1024;

   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [2:0]   idx;
      logic [63:0]  value;   // register data or data_block
      logic [3:0]   nv;
      logic         last;
      logic         typed;
      logic [63:0]  mac;
      logic [1:0]   status;
   } row_type;

   typedef struct packed {
      logic [63:0] mac;
      logic [1:0]  status;
   } mac_result_type;

   localparam int NUM_ROWS = 30;
   localparam row_type DIRECTED [NUM_ROWS] = '{
      '{ROW_ITEM, REG_KEY_ONE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'h0, 4'd1, 1'b1, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'h1122_3344_5566_7788, 4'd0, 1'b1, 1'b1, 64'd0,
        STATUS_BAD_PARM},
      '{ROW_ITEM, REG_KEY_ONE, 64'hA5A5_5A5A_0F0F_F0F0, 4'd15, 1'b1, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'h0123_4567_89AB_CDEF, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'hDEAD_BEEF_CAFE_F00D, 4'd3, 1'b1, 1'b0, 64'd0, STATUS_OK},
      '{ROW_CFG, REG_MAC_MODE, 64'h10, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd5, 1'b1, 1'b0, 64'd0, STATUS_OK},
      '{ROW_CFG, REG_KEY_ONE, 64'h0123_4567_89AB_CDEF, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_CFG, REG_KEY_TWO, 64'hFEDC_BA98_7654_3210, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_CFG, REG_KEY_LEN, 64'd16, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'h4E6F_7720_6973_2074, 4'd8, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'h6865_2074_696D_6520, 4'd7, 1'b1, 1'b0, 64'd0, STATUS_OK},
      '{ROW_CFG, REG_KEY_THREE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_CFG, REG_KEY_LEN, 64'd24, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'h0, 4'd8, 1'b1, 1'b0, 64'd0, STATUS_OK},
      '{ROW_CFG, REG_MAC_MODE, 64'h02, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'h8000_0000_0000_0001, 4'd8, 1'b1, 1'b0, 64'd0, STATUS_OK},
      '{ROW_CFG, REG_KEY_LEN, 64'd16, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'h1357_9BDF_0246_8ACE, 4'd2, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'hFF00_FF00_FF00_FF00, 4'd1, 1'b1, 1'b0, 64'd0, STATUS_OK},
      '{ROW_CFG, REG_MAC_MODE, 64'h03, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'h1, 4'd8, 1'b1, 1'b1, 64'd0, STATUS_BAD_PARM},
      '{ROW_CFG, REG_MAC_MODE, 64'h20, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'h2, 4'd8, 1'b1, 1'b1, 64'd0, STATUS_BAD_PARM},
      '{ROW_CFG, REG_MAC_MODE, 64'h12, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_CFG, REG_KEY_LEN, 64'd31, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'h3, 4'd4, 1'b1, 1'b1, 64'd0, STATUS_BAD_PARM},
      '{ROW_CFG, REG_KEY_LEN, 64'd0, 4'd0, 1'b0, 1'b0, 64'd0, STATUS_OK},
      '{ROW_ITEM, REG_KEY_ONE, 64'h4, 4'd8, 1'b1, 1'b1, 64'd0, STATUS_BAD_PARM}
   };

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // data_block[63:0], valid_bytes[67:64], zero fill
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // mac_value[63:0]
   logic [1:0]  rsp_tuser;   // status[1:0]
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_data;

   // predictor copy of registers and chaining state
   logic [63:0] key_a, key_b, key_c;
   logic [4:0]  key_len;
   logic [7:0]  mode;
   logic [63:0] chain;
   int          byte_count;
   logic        over_limit;

   mac_result_type pending_macs [$];
   int             fail_count;
   int             requests_taken;
   bit             req_on;
   bit             csr_on;

   des_cbc_retail_mac i_dut (.*);

   always #2 clock = ~clock;

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] k);
      logic [47:0] e;
      logic [5:0]  b;
      logic [31:0] s;
      logic [31:0] p;
      for (int i = 0; i < 48; i++) e[47-i] = r[32-TAB_E[i]];
      e = e ^ k;
      for (int i = 0; i < 8; i++) begin
         b = e[47-6*i -: 6];
         s[31-4*i -: 4] = TAB_S[i][{b[5], b[0], b[4:1]}];
      end
      for (int i = 0; i < 32; i++) p[31-i] = s[32-TAB_P[i]];
      return p;
   endfunction

   function automatic logic [63:0] des_block(input logic [63:0] blk, input logic [63:0] key,
                                             input bit decrypt);
      logic [55:0] cd;
      logic [27:0] c, d;
      logic [47:0] sub [16];
      logic [63:0] ip, pre, res;
      logic [31:0] l, r, t;
      for (int i = 0; i < 56; i++) cd[55-i] = key[64-TAB_PC1[i]];
      c = cd[55:28];
      d = cd[27:0];
      for (int i = 0; i < 16; i++) begin
         for (int s = 0; s < TAB_ROT[i]; s++) begin
            c = {c[26:0], c[27]};
            d = {d[26:0], d[27]};
         end
         cd = {c, d};
         for (int j = 0; j < 48; j++) sub[i][47-j] = cd[56-TAB_PC2[j]];
      end
      for (int i = 0; i < 64; i++) ip[63-i] = blk[64-TAB_IP[i]];
      l = ip[63:32];
      r = ip[31:0];
      for (int i = 0; i < 16; i++) begin
         t = l ^ round_f(r, sub[decrypt ? 15 - i : i]);
         l = r;
         r = t;
      end
      pre = {r, l};
      for (int i = 0; i < 64; i++) res[63-i] = pre[64-TAB_FP[i]];
      return res;
   endfunction

   function automatic logic [63:0] block_cipher(input logic [63:0] x);
      logic [63:0] y;
      if (mode[3:0] == ALG_THREE || (key_len != KEYLEN_DOUBLE && key_len != KEYLEN_TRIPLE))
         return des_block(x, key_a, 1'b0);
      y = des_block(x, key_a, 1'b0);
      y = des_block(y, key_b, 1'b1);
      return des_block(y, key_len == KEYLEN_TRIPLE ? key_c : key_a, 1'b0);
   endfunction

   // advances the chain by one block; returns 1 when a mac comes out
   function automatic bit predict_mac(input logic [63:0] data_in, input logic [3:0] nv_in,
                                      input logic last, output mac_result_type res);
      logic [63:0] data;
      int          nv;
      bit          bad;
      data = data_in;
      nv = last ? int'(nv_in) : 8;
      if (nv > 8) nv = 8;
      bad = (mode[7:4] != PAD_ZERO && mode[7:4] != PAD_ISO) ||
            (mode[3:0] != ALG_ONE && mode[3:0] != ALG_THREE) ||
            (key_len != KEYLEN_SINGLE && key_len != KEYLEN_DOUBLE &&
             key_len != KEYLEN_TRIPLE) || (last && nv == 0);
      if (nv > 0 && nv < 8) begin
         data = data & (~64'd0 << (64 - 8 * nv));
         if (mode[7:4] == PAD_ISO) data = data | (64'h80 << (56 - 8 * nv));
      end
      if (nv > 0) chain = block_cipher(chain ^ data);
      byte_count += nv;
      if (byte_count > MAX_MSG) begin
         over_limit = 1'b1;
         byte_count = MAX_MSG + 1;
      end
      if (!last) return 1'b0;
      res.mac = 64'd0;
      if (bad) begin
         res.status = STATUS_BAD_PARM;
      end else if (over_limit) begin
         res.status = STATUS_TOO_LONG;
      end else begin
         res.status = STATUS_OK;
         res.mac = chain;
         if (mode[3:0] == ALG_THREE && key_len != KEYLEN_SINGLE) begin
            res.mac = des_block(res.mac, key_b, 1'b1);
            res.mac = des_block(res.mac, key_len == KEYLEN_TRIPLE ? key_c : key_a, 1'b0);
         end
      end
      chain = 64'd0;
      byte_count = 0;
      over_limit = 1'b0;
      return 1'b1;
   endfunction

   // all tasks start and end at a falling edge
   task automatic send_request(input logic [63:0] data, input logic [3:0] nv, input logic last,
                               input bit typed, input mac_result_type typed_res);
      mac_result_type res;
      if (csr_on) csr_valid <= 1'b0;
      csr_on = 1'b0;
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, nv, data};
      req_tlast  <= last;
      req_on = 1'b1;
      do @(posedge clock); while (!req_tready);
      requests_taken++;
      if (predict_mac(data, nv, last, res)) pending_macs.push_back(typed ? typed_res : res);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      if (req_on) req_tvalid <= 1'b0;
      req_on = 1'b0;
      if (!csr_on) begin
         while (pending_macs.size() != 0) @(negedge clock);
         // a non-last block may still be in the engine
         repeat (DRAIN_CYCLES) @(negedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      csr_on = 1'b1;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_KEY_ONE:   key_a = value;
         REG_KEY_TWO:   key_b = value;
         REG_KEY_THREE: key_c = value;
         REG_KEY_LEN:   key_len = value[4:0];
         REG_MAC_MODE:  mode = value[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic random_write();
      logic [2:0]  idx;
      logic [63:0] value;
      int          pick;
      idx = 3'($urandom_range(0, 4));
      pick = $urandom_range(0, 9);
      case (idx)
         REG_KEY_LEN: begin
            if (pick < 3) value = 64'(KEYLEN_SINGLE);
            else if (pick < 6) value = 64'(KEYLEN_DOUBLE);
            else if (pick < 9) value = 64'(KEYLEN_TRIPLE);
            else value = 64'($urandom_range(0, 31));
         end
         REG_MAC_MODE: begin
            if (pick < 9)
               value = {56'd0, ($urandom_range(0, 1) ? PAD_ISO : PAD_ZERO),
                        ($urandom_range(0, 1) ? ALG_THREE : ALG_ONE)};
            else value = 64'($urandom_range(0, 255));
         end
         default: value = {$urandom, $urandom};
      endcase
      write_reg(idx, value);
   endtask

   // random pause between bursts of requests
   int burst_left;
   task automatic sender_gap();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = $urandom_range(0, 12);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_on = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // receiver stall pattern with one long hold-off
   initial begin
      int  hold;
      int  stretch;
      bit  held_once;
      bit  level;
      hold = 0;
      stretch = 0;
      held_once = 0;
      level = 1'b1;
      forever begin
         @(negedge clock);
         if (!held_once && requests_taken >= 140) begin
            held_once = 1;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(1, 30);
               level = $urandom_range(0, 2) != 0;
            end
            stretch--;
            rsp_tready <= level ? 1'b1 : 1'($urandom_range(0, 1));
         end
      end
   end

   always @(posedge clock) begin
      mac_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_macs.size() == 0) begin
            $display("%0t: unexpected mac %h status %0d", $time, rsp_tdata, rsp_tuser);
            fail_count++;
         end else begin
            want = pending_macs.pop_front();
            if (rsp_tdata !== want.mac) begin
               $display("%0t: mac expected %h actual %h", $time, want.mac, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   initial begin
      mac_result_type typed_res;
      int             msg_no;
      int             blocks;
      logic [3:0]     nv;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      key_a = '0;
      key_b = '0;
      key_c = '0;
      key_len = KEYLEN_SINGLE;
      mode = 8'd0;
      chain = '0;
      byte_count = 0;
      over_limit = 1'b0;
      fail_count = 0;
      requests_taken = 0;
      req_on = 0;
      csr_on = 0;
      burst_left = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].kind == ROW_CFG) begin
            write_reg(DIRECTED[i].idx, DIRECTED[i].value);
         end else begin
            typed_res.mac = DIRECTED[i].mac;
            typed_res.status = DIRECTED[i].status;
            send_request(DIRECTED[i].value, DIRECTED[i].nv, DIRECTED[i].last,
                         DIRECTED[i].typed, typed_res);
         end
      end

      msg_no = 0;
      while (requests_taken < ITEM_TARGET) begin
         if (msg_no == 6 || msg_no == 12) begin
            // one message of exactly the limit, one just past it
            write_reg(REG_MAC_MODE, {56'd0, PAD_ISO, ALG_ONE});
            write_reg(REG_KEY_LEN, 64'(KEYLEN_SINGLE));
            blocks = MAX_MSG / 8 + (msg_no == 12 ? 1 : 0);
         end else begin
            while ($urandom_range(0, 3) == 0) random_write();
            blocks = $urandom_range(1, 6);
         end
         for (int b = 1; b <= blocks; b++) begin
            if (b < blocks) nv = 4'($urandom_range(0, 15));
            else if (blocks > MAX_MSG / 8) nv = 4'($urandom_range(1, 8));
            else if (blocks == MAX_MSG / 8) nv = 4'd8;
            else if ($urandom_range(0, 4) != 0) nv = 4'($urandom_range(1, 8));
            else nv = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
            send_request({$urandom, $urandom}, nv, b == blocks, 1'b0, typed_res);
            sender_gap();
         end
         msg_no++;
      end
      req_tvalid <= 1'b0;
      csr_valid <= 1'b0;

      while (pending_macs.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_macs.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dcrm_pkg.sv
hdl/dcrm_front.sv
hdl/dcrm_queue.sv
hdl/dcrm_engine.sv
hdl/des_cbc_retail_mac.sv
verif/tb_des_cbc_retail_mac.sv
